// File: rtl/depth_first_search_order_defines.svh
// Assertion macros for the RTL file that carries checks, dfso_dp.sv.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef DEPTH_FIRST_SEARCH_ORDER_DEFINES_SVH
`define DEPTH_FIRST_SEARCH_ORDER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DFSO_CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DFSO_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/dfso_pkg.sv
`default_nettype none
package dfso_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int VTX_W            = 7;
  localparam int ROW_IDX_W        = 6;
  localparam int ROW_W            = 64;
  localparam logic [VTX_W-1:0] VC_RESET = 7'd64;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_SCAN  = 4'b0100,
    S_POP   = 4'b1000
  } state_t;

  typedef struct packed {
    logic load_row;
    logic run_init;
    logic run_err;
    logic push;
    logic pop;
    logic pop_fetch;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic start_ok;
    logic has_next;
    logic depth_one;
  } dp_stat_t;

endpackage
`default_nettype wire

// File: rtl/dfso_ctrl.sv
`default_nettype none
module dfso_ctrl import dfso_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire logic     in_operation,
  input  wire dp_stat_t stat,
  output logic          busy,
  output dp_cmd_t       cmd
);

  state_t state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_operation == OP_LOAD) begin
            cmd.load_row = 1'b1;
          end else if (stat.start_ok) begin
            cmd.run_init = 1'b1;
            state_nxt    = S_FETCH;
          end else begin
            cmd.run_err = 1'b1;
          end
        end
      end
      S_FETCH: begin
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (stat.has_next) begin
          cmd.push = 1'b1;
        end else if (stat.depth_one) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        cmd.pop_fetch = 1'b1;
        state_nxt     = S_SCAN;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/dfso_dp.sv
`default_nettype none
`include "depth_first_search_order_defines.svh"
module dfso_dp import dfso_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [VTX_W-1:0]     cfg_wdata,
  input  wire logic [ROW_IDX_W-1:0] in_row_index,
  input  wire logic [ROW_W-1:0]     in_row_bits,
  input  wire logic [VTX_W-1:0]     in_start_vertex,
  input  wire dp_cmd_t              cmd,
  output dp_stat_t                  stat,
  output logic                      strobe,
  output logic [VTX_W-1:0]          out_visited_vertex,
  output logic                      out_last,
  output logic                      out_error
);

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int DW = $clog2(MAX_VERTICES + 1);

  logic [VTX_W-1:0]        vc_r;
  logic [MAX_VERTICES-1:0] row_ok_r;
  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] adj_rd_r;
  logic                    adj_ok_r;
  logic [IW-1:0]           stk_mem [MAX_VERTICES];
  logic [IW-1:0]           stk_rd_r;

  logic [MAX_VERTICES-1:0] visited_r, visited_nxt;
  logic [DW-1:0]           depth_r, depth_nxt;
  logic [IW-1:0]           cur_r, cur_nxt;
  logic [VTX_W-1:0]        pend_r, pend_nxt;
  logic                    strobe_r, strobe_nxt;
  logic [VTX_W-1:0]        vtx_r, vtx_nxt;
  logic                    last_r, last_nxt;
  logic                    err_r, err_nxt;

  logic [VTX_W-1:0]        n_lim;
  logic [MAX_VERTICES-1:0] nmask, adj_row, masked, lowbit;
  logic [IW-1:0]           next_i;
  logic [VTX_W-1:0]        start_m1;
  logic [IW-1:0]           start_idx;
  logic                    row_in_range;
  logic [IW-1:0]           adj_raddr;
  logic [DW-1:0]           depth_m2;
  logic [IW-1:0]           stk_raddr;
  logic [IW-1:0]           stk_waddr;
  logic [IW-1:0]           stk_wdata;

  // Vertex count clamps to the storage size; edges past it are masked off.
  assign n_lim = (vc_r > VTX_W'(MAX_VERTICES)) ? VTX_W'(MAX_VERTICES) : vc_r;

  always_comb begin
    for (int j = 0; j < MAX_VERTICES; j++) begin
      nmask[j] = (VTX_W'(j) < n_lim);
    end
  end

  // Lowest unvisited neighbour: isolate the lowest set bit, then encode it.
  assign adj_row = adj_ok_r ? adj_rd_r : '0;
  assign masked  = adj_row & ~visited_r & nmask;
  assign lowbit  = masked & (~masked + MAX_VERTICES'(1));

  always_comb begin
    next_i = '0;
    for (int j = 0; j < MAX_VERTICES; j++) begin
      if (lowbit[j]) begin
        next_i = next_i | IW'(j);
      end
    end
  end

  assign start_m1     = in_start_vertex - 7'd1;
  assign start_idx    = start_m1[IW-1:0];
  assign row_in_range = ({1'b0, in_row_index} < VTX_W'(MAX_VERTICES));

  assign stat.start_ok  = (in_start_vertex != '0) && (in_start_vertex <= n_lim);
  assign stat.has_next  = |masked;
  assign stat.depth_one = (depth_r == DW'(1));

  assign adj_raddr = cmd.push ? next_i : (cmd.pop_fetch ? stk_rd_r : cur_r);
  assign depth_m2  = depth_r - DW'(2);
  assign stk_raddr = depth_m2[IW-1:0];
  assign stk_waddr = cmd.run_init ? '0 : depth_r[IW-1:0];
  assign stk_wdata = cmd.run_init ? start_idx : next_i;

  always_comb begin
    visited_nxt = visited_r;
    depth_nxt   = depth_r;
    cur_nxt     = cur_r;
    pend_nxt    = pend_r;
    strobe_nxt  = 1'b0;
    vtx_nxt     = vtx_r;
    last_nxt    = last_r;
    err_nxt     = err_r;
    if (cmd.run_err) begin
      visited_nxt = '0;
      depth_nxt   = '0;
      strobe_nxt  = 1'b1;
      vtx_nxt     = '0;
      last_nxt    = 1'b1;
      err_nxt     = 1'b1;
    end
    if (cmd.run_init) begin
      visited_nxt            = '0;
      visited_nxt[start_idx] = 1'b1;
      depth_nxt              = DW'(1);
      cur_nxt                = start_idx;
      pend_nxt               = in_start_vertex;
    end
    if (cmd.push) begin
      // The held vertex goes out now; the new one waits to learn if it is last.
      visited_nxt[next_i] = 1'b1;
      depth_nxt           = depth_r + DW'(1);
      cur_nxt             = next_i;
      pend_nxt            = VTX_W'(next_i) + 7'd1;
      strobe_nxt          = 1'b1;
      vtx_nxt             = pend_r;
      last_nxt            = 1'b0;
      err_nxt             = 1'b0;
    end
    if (cmd.pop) begin
      depth_nxt = depth_r - DW'(1);
    end
    if (cmd.pop_fetch) begin
      cur_nxt = stk_rd_r;
    end
    if (cmd.finish) begin
      depth_nxt  = '0;
      strobe_nxt = 1'b1;
      vtx_nxt    = pend_r;
      last_nxt   = 1'b1;
      err_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r      <= VC_RESET;
      row_ok_r  <= '0;
      visited_r <= '0;
      depth_r   <= '0;
      strobe_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        vc_r <= cfg_wdata;
      end
      if (cmd.load_row && row_in_range) begin
        row_ok_r[in_row_index[IW-1:0]] <= 1'b1;
      end
      visited_r <= visited_nxt;
      depth_r   <= depth_nxt;
      strobe_r  <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    pend_r   <= pend_nxt;
    vtx_r    <= vtx_nxt;
    last_r   <= last_nxt;
    err_r    <= err_nxt;
    adj_ok_r <= row_ok_r[adj_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_row && row_in_range) begin
      adj_mem[in_row_index[IW-1:0]] <= in_row_bits[MAX_VERTICES-1:0];
    end
    adj_rd_r <= adj_mem[adj_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.run_init || cmd.push) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rd_r <= stk_mem[stk_raddr];
  end

  assign strobe             = strobe_r;
  assign out_visited_vertex = vtx_r;
  assign out_last           = last_r;
  assign out_error          = err_r;

  `DFSO_CHK_NOW(a_push_room, cmd.push, depth_r < DW'(MAX_VERTICES), "stack overflow on push")
  `DFSO_CHK_NEXT(a_push_marks, cmd.push, visited_r[cur_r], "pushed vertex not marked")
  `DFSO_CHK_NEXT(a_finish_empty, cmd.finish, depth_r == '0 && strobe_r && last_r, "bad run end")
  `DFSO_CHK_NOW(a_good_nonzero, strobe_r && !err_r, vtx_r != '0, "zero vertex without error")

endmodule
`default_nettype wire

// File: rtl/depth_first_search_order.sv
// Depth-first traversal engine over a stored adjacency matrix.
// Input items are offered on start with the in_ fields and are taken at a
// clock edge where start is high and busy is low. A load item (operation 0)
// writes one adjacency row and leaves busy low, so loads may stream back to
// back. A run item (operation 1) with a good start vertex walks the graph
// from in_start_vertex and raises busy until its final result is produced.
// Results appear on the out_ ports for one cycle each, marked by strobe; the
// receiver cannot stall them, and the final result of a run carries out_last.
// A bad start vertex gives one error result in the cycle after acceptance.
// A good run emits its first result after its fetch and scan steps. Each
// discovery is made in the scan step and each backtrack also passes through
// the pop step, because the new top of stack must come out of the stack
// memory before its adjacency row can be read.
// Reset clears all rows to empty through per-row valid bits, sets the vertex
// count to 64 and returns the controller to idle. cfg_we writes the vertex
// count and is meant to be used only while the block is idle.
`default_nettype none
module depth_first_search_order import dfso_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 in_operation,
  input  wire logic [ROW_IDX_W-1:0] in_row_index,
  input  wire logic [ROW_W-1:0]     in_row_bits,
  input  wire logic [VTX_W-1:0]     in_start_vertex,
  input  wire logic                 cfg_we,
  input  wire logic [VTX_W-1:0]     cfg_wdata,
  output logic                      strobe,
  output logic [VTX_W-1:0]          out_visited_vertex,
  output logic                      out_last,
  output logic                      out_error
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller sequences fetch, scan and backtrack steps; the datapath
  // owns the row memory, the stack memory, the visit marks and the result
  // register that holds each discovered item until its successor is known.
  dfso_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .stat         (stat),
    .busy         (busy),
    .cmd          (cmd)
  );

  dfso_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_row_index       (in_row_index),
    .in_row_bits        (in_row_bits),
    .in_start_vertex    (in_start_vertex),
    .cmd                (cmd),
    .stat               (stat),
    .strobe             (strobe),
    .out_visited_vertex (out_visited_vertex),
    .out_last           (out_last),
    .out_error          (out_error)
  );

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

// Self-checking testbench for the depth-first traversal engine.
//
// Items are offered on start together with the in_ fields and are taken at a
// rising edge where start is high and busy is low. Every taken item is run
// through a local model of the traversal, and the vertices it is expected to
// discover are queued in order. A checker process pops one expectation for
// each strobe and compares all three result fields. Inputs change on the
// falling edge, and outputs are sampled on the rising edge.
module tb_top;
  import dfso_pkg::*;

  // Generous bound on the whole run. The slowest correct run is roughly
  // 470 items plus sender gaps.
  localparam int LIMIT_CYCLES = 600000;
  localparam int NV = MAX_VERTICES_DEF;

  typedef struct packed {
    logic [VTX_W-1:0] vertex;
    logic             last;
    logic             error;
  } visit_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic                 in_operation;
  logic [ROW_IDX_W-1:0] in_row_index;
  logic [ROW_W-1:0]     in_row_bits;
  logic [VTX_W-1:0]     in_start_vertex;
  logic                 cfg_we;
  logic [VTX_W-1:0]     cfg_wdata;
  logic                 strobe;
  logic [VTX_W-1:0]     out_visited_vertex;
  logic                 out_last;
  logic                 out_error;

  // Local copy of the block's state: the adjacency matrix and the register.
  logic [ROW_W-1:0] adj_rows [NV];
  logic [VTX_W-1:0] vertex_limit;

  // Vertices still to be discovered, oldest first.
  visit_t discovery_q [$];

  int fail_cnt;
  int cycle_cnt;
  int item_cnt;
  int burst_left;

  depth_first_search_order u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_operation       (in_operation),
    .in_row_index       (in_row_index),
    .in_row_bits        (in_row_bits),
    .in_start_vertex    (in_start_vertex),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .strobe             (strobe),
    .out_visited_vertex (out_visited_vertex),
    .out_last           (out_last),
    .out_error          (out_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run is stopped if it hangs; a correct block never comes near this.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // Model of one item. A load only updates the matrix. A run clears the
  // visit marks, then walks depth first with an explicit stack, always
  // descending into the lowest-numbered unvisited neighbour below the
  // vertex count. The discovery order is queued with last on the final one.
  task automatic walk_graph(input logic op, input logic [ROW_IDX_W-1:0] row,
                            input logic [ROW_W-1:0] bits,
                            input logic [VTX_W-1:0] sv);
    int n;
    int depth;
    int count;
    int u;
    int i;
    bit pushed;
    logic [1:0]       color [NV];
    logic [5:0]       stack [NV];
    logic [VTX_W-1:0] order [NV];
    visit_t           r;
    if (op == OP_LOAD) begin
      adj_rows[row] = bits;
      return;
    end
    n = (vertex_limit > NV) ? NV : int'(vertex_limit);
    for (i = 0; i < NV; i++) color[i] = 2'd0;
    // An out-of-range start, including zero, yields a single error result.
    if (sv == 0 || int'(sv) > n) begin
      r.vertex = '0;
      r.last   = 1'b1;
      r.error  = 1'b1;
      discovery_q.push_back(r);
      return;
    end
    stack[0] = 6'(sv - 1);
    depth = 1;
    color[sv - 1] = 2'd1;
    order[0] = sv;
    count = 1;
    while (depth > 0) begin
      u = int'(stack[depth - 1]);
      pushed = 1'b0;
      for (i = 0; i < n; i++) begin
        if (adj_rows[u][i] && color[i] == 2'd0) begin
          if (depth < NV && count < NV) begin
            stack[depth] = 6'(i);
            depth++;
            color[i] = 2'd1;
            order[count] = VTX_W'(i + 1);
            count++;
            pushed = 1'b1;
          end
          break;
        end
      end
      // No unvisited neighbour is left, so this vertex is finished.
      if (!pushed) begin
        depth--;
        color[u] = 2'd2;
      end
    end
    for (i = 0; i < count; i++) begin
      r.vertex = order[i];
      r.last   = (i == count - 1);
      r.error  = 1'b0;
      discovery_q.push_back(r);
    end
  endtask

  // Holds start low for the given number of cycles.
  task automatic pause_sender(input int cycles);
    repeat (cycles) @(negedge clk) start <= 1'b0;
  endtask

  // Offers one item and returns at the edge where it is taken. Start is left
  // high so that the next item may follow without a gap; the sender works in
  // bursts and drops start for a random gap once a burst is used up.
  task automatic offer_item(input logic op, input logic [ROW_IDX_W-1:0] row,
                            input logic [ROW_W-1:0] bits,
                            input logic [VTX_W-1:0] sv);
    @(negedge clk);
    start           <= 1'b1;
    in_operation    <= op;
    in_row_index    <= row;
    in_row_bits     <= bits;
    in_start_vertex <= sv;
    do @(posedge clk); while (busy);
    walk_graph(op, row, bits, sv);
    item_cnt++;
    burst_left--;
    if (burst_left <= 0) begin
      // Now and then a long burst gives a stretch without any idling.
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
      pause_sender($urandom_range(1, 6));
    end
  endtask

  task automatic offer_load(input int row, input logic [ROW_W-1:0] bits);
    offer_item(OP_LOAD, ROW_IDX_W'(row), bits, VTX_W'($urandom));
  endtask

  // The load fields are ignored on a run, so they carry random content.
  task automatic offer_run(input int sv);
    offer_item(OP_RUN, ROW_IDX_W'($urandom), {$urandom, $urandom}, VTX_W'(sv));
  endtask

  // Stops sending and waits until every expected result has arrived and the
  // block has gone idle, then waits on for any load still settling.
  task automatic wait_drained();
    pause_sender(1);
    while (discovery_q.size() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // The vertex count is only written while the block is idle.
  task automatic write_vertex_count(input int value);
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= VTX_W'(value);
    @(negedge clk);
    cfg_we    <= 1'b0;
    vertex_limit = VTX_W'(value);
  endtask

  // Random adjacency row with a density picked by mode.
  function automatic logic [ROW_W-1:0] rand_row(input int mode);
    logic [ROW_W-1:0] a;
    logic [ROW_W-1:0] b;
    logic [ROW_W-1:0] c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case (mode)
      0: return a;
      1: return a & b & c;
      2: return 64'h1 << $urandom_range(0, 63);
      3: return a | b;
      4: return '0;
      default: return '1;
    endcase
  endfunction

  // Checks every strobed result against the oldest expectation.
  always @(posedge clk) begin
    visit_t want;
    if (rst_n && strobe) begin
      if (discovery_q.size() == 0) begin
        $display("%0t: unexpected result vertex %0d last %0d error %0d", $realtime,
                 out_visited_vertex, out_last, out_error);
        fail_cnt++;
      end else begin
        want = discovery_q.pop_front();
        if (out_visited_vertex !== want.vertex) begin
          $display("%0t: visited_vertex expected %0d actual %0d", $realtime,
                   want.vertex, out_visited_vertex);
          fail_cnt++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last expected %0d actual %0d", $realtime, want.last, out_last);
          fail_cnt++;
        end
        if (out_error !== want.error) begin
          $display("%0t: error expected %0d actual %0d", $realtime, want.error, out_error);
          fail_cnt++;
        end
      end
    end
  end

  // With every row empty after reset, a good start discovers only itself.
  // Starts of zero and above the count must report an error.
  task automatic test_reset_defaults();
    offer_run(1);
    offer_run(64);
    offer_run(0);
    offer_run(65);
    offer_run(127);
  endtask

  // A row of all ones from vertex 0 reaches every vertex, which gives the
  // longest run. Row 63 also has a self loop, which must be ignored.
  task automatic test_full_reach();
    offer_load(0, '1);
    offer_run(1);
    offer_load(63, 64'h8000_0000_0000_0001);
    offer_run(64);
    offer_run(5);
  endtask

  // A count of zero fails every run, one allows only vertex 1, a count above
  // the maximum acts as the maximum, and a small count hides higher edges.
  task automatic test_vertex_count_limits();
    write_vertex_count(0);
    offer_run(1);
    write_vertex_count(1);
    offer_run(1);
    offer_run(2);
    write_vertex_count(127);
    offer_run(1);
    write_vertex_count(10);
    offer_run(1);
    offer_run(10);
    offer_run(11);
    write_vertex_count(64);
  endtask

  // Random graphs under a spread of vertex counts. Most of the stimulus loads
  // a few rows and then runs from a vertex in range; some of it builds long
  // chains for a deep stack, and the rest is fully random noise.
  task automatic test_random_graphs();
    int phase_vc [10];
    int p;
    int n;
    int k;
    int j;
    int s;
    int mode;
    int goal;
    phase_vc = '{64, 6, 127, 1, 40, 0, 2, 65, 17, 64};
    for (p = 0; p < 10; p++) begin
      write_vertex_count(phase_vc[p]);
      n = (phase_vc[p] > NV) ? NV : phase_vc[p];
      goal = item_cnt + 44;
      while (item_cnt < goal) begin
        mode = $urandom_range(0, 99);
        if (mode < 70 && n > 0) begin
          k = $urandom_range(1, 6);
          for (j = 0; j < k; j++)
            offer_load($urandom_range(0, n - 1), rand_row($urandom_range(0, 5)));
          k = $urandom_range(1, 3);
          for (j = 0; j < k; j++)
            offer_run(($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                  : $urandom_range(1, n));
        end else if (mode < 85 && n > 1) begin
          s = $urandom_range(0, n - 1);
          k = $urandom_range(2, 10);
          for (j = 0; j < k; j++)
            offer_load((s + j) % n, (64'h1 << ((s + j + 1) % n)) | rand_row(2));
          offer_run(s + 1);
        end else begin
          offer_item(1'($urandom_range(0, 1)), ROW_IDX_W'($urandom), rand_row(0),
                     VTX_W'($urandom));
        end
        // In one phase, near its end, the sender also waits for the block to drain.
        if (p == 4 && item_cnt >= goal - 20 && item_cnt < goal - 15)
          wait_drained();
      end
    end
  endtask

  initial begin
    start           = 1'b0;
    in_operation    = OP_LOAD;
    in_row_index    = '0;
    in_row_bits     = '0;
    in_start_vertex = '0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    rst_n           = 1'b0;
    fail_cnt        = 0;
    cycle_cnt       = 0;
    item_cnt        = 0;
    burst_left      = 1;
    vertex_limit    = VC_RESET;
    for (int i = 0; i < NV; i++) adj_rows[i] = '0;

    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_reset_defaults();
    test_full_reach();
    test_vertex_count_limits();
    test_random_graphs();

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_cnt == 0 && discovery_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
